[design/ats_pkg.sv]
// Shared types, token codes and the mnemonic table of the assembly token scanner.
package ats_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} ats_in_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] start_line;
		logic [11:0] start_column;
		logic [3:0]  lexeme_length;
		logic [63:0] lexeme_bytes;
		logic        last_of_run;
	} ats_out_t;

	// Tokens produced by one text byte: count is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] count;
		ats_out_t   first;
		ats_out_t   second;
	} ats_pair_t;

	localparam int NUM_MNEMONICS = 28;

	localparam logic [5:0] KIND_LABEL     = 6'd28;
	localparam logic [5:0] KIND_LABEL_DEF = 6'd29;
	localparam logic [5:0] KIND_INT       = 6'd30;
	localparam logic [5:0] KIND_FLOAT     = 6'd31;
	localparam logic [5:0] KIND_CHAR      = 6'd32;
	localparam logic [5:0] KIND_UNCLOSED  = 6'd33;
	localparam logic [5:0] KIND_TOO_LONG  = 6'd34;

	localparam logic [7:0] CHR_COLON   = 8'h3A;
	localparam logic [7:0] CHR_DOT     = 8'h2E;
	localparam logic [7:0] CHR_SEMI    = 8'h3B;
	localparam logic [7:0] CHR_QUOTE   = 8'h27;
	localparam logic [7:0] CHR_NEWLINE = 8'h0A;

	localparam logic [15:0] LINE_MAX = 16'hFFFF;
	localparam logic [11:0] COL_MAX  = 12'hFFF;

	// Mnemonic text packed as the lexeme store holds it: first letter in the low byte,
	// so each string literal is written back to front.
	function automatic logic [63:0] mnemonic_text(input logic [4:0] code);
		logic [63:0] v;
		unique case (code)
			5'd0:    v = {40'd0, "pon"};
			5'd1:    v = {32'd0, "hsup"};
			5'd2:    v = {40'd0, "pop"};
			5'd3:    v = {40'd0, "pud"};
			5'd4:    v = {24'd0, "pudni"};
			5'd5:    v = {32'd0, "paws"};
			5'd6:    v = {16'd0, "pawsni"};
			5'd7:    v = {40'd0, "dda"};
			5'd8:    v = {40'd0, "bus"};
			5'd9:    v = {40'd0, "lum"};
			5'd10:   v = {40'd0, "vid"};
			5'd11:   v = {40'd0, "dom"};
			5'd12:   v = {32'd0, "fdda"};
			5'd13:   v = {32'd0, "fbus"};
			5'd14:   v = {32'd0, "flum"};
			5'd15:   v = {32'd0, "fvid"};
			5'd16:   v = {32'd0, "fdom"};
			5'd17:   v = {32'd0, "epmc"};
			5'd18:   v = {24'd0, "enpmc"};
			5'd19:   v = {32'd0, "gpmc"};
			5'd20:   v = {32'd0, "lpmc"};
			5'd21:   v = {24'd0, "egpmc"};
			5'd22:   v = {24'd0, "elpmc"};
			5'd23:   v = {40'd0, "pmj"};
			5'd24:   v = {32'd0, "pmjz"};
			5'd25:   v = {24'd0, "pmjzn"};
			5'd26:   v = {24'd0, "tnirp"};
			5'd27:   v = {32'd0, "tlah"};
			default: v = '1;
		endcase
		return v;
	endfunction

	// Kind of a finished word. Bytes past the count are zero, so a full-width
	// compare also checks the length.
	function automatic logic [5:0] word_kind(input logic [63:0] store, input logic too_long,
			input logic colon);
		logic [5:0] kind;
		logic       hit;
		hit  = 1'b0;
		kind = colon ? KIND_LABEL_DEF : KIND_LABEL;
		for (int k = 0; k < NUM_MNEMONICS; k++) begin
			if (!hit && store == mnemonic_text(5'(k))) begin
				hit  = 1'b1;
				kind = 6'(k);
			end
		end
		if (too_long) begin
			kind = KIND_TOO_LONG;
		end
		return kind;
	endfunction

endpackage

[design/assembly_token_scanner_top.sv]
// Top level of the assembly token scanner: input register, scanner and result register.
// A byte passes the input register, then its tokens wait until the result register is
// free and are loaded into it, and are offered from there. One byte is taken per cycle
// while each byte yields at most one token and the output takes each token; a byte that
// yields two tokens holds the result register until both have been handed out.
// Reset puts the scanner idle at line 1, column 1 and empties both registers at once.
module assembly_token_scanner_top #(
	parameter int MAX_LEXEME = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ats_pkg::ats_in_t  in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output ats_pkg::ats_out_t out_word
);
	import ats_pkg::*;

	ats_in_t   word_s1;
	logic      valid_s1;
	ats_pair_t pair;
	logic      advance, out_free;

	// A byte that yields no token can move on even while the result register is busy.
	assign advance  = valid_s1 && (out_free || pair.count == 2'd0);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

	ats_scan #(
		.MAX_LEXEME(MAX_LEXEME)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.word  (word_s1),
		.pair  (pair)
	);

	ats_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && pair.count != 2'd0),
		.pair     (pair),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_word (out_word),
		.free     (out_free)
	);

endmodule

[design/ats_scan.sv]
// Scanner state and the single-pass token logic for one text byte.
module ats_scan #(
	parameter int MAX_LEXEME = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ats_pkg::ats_in_t word,
	output ats_pkg::ats_pair_t pair
);
	import ats_pkg::*;

	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_WORD       = 3'd1;
	localparam logic [2:0] MODE_INT        = 3'd2;
	localparam logic [2:0] MODE_FLOAT      = 3'd3;
	localparam logic [2:0] MODE_CHAR_OPEN  = 3'd4;
	localparam logic [2:0] MODE_CHAR_CLOSE = 3'd5;
	localparam logic [2:0] MODE_COMMENT    = 3'd6;

	localparam logic [3:0] MAX_LEN = 4'(MAX_LEXEME);

	logic [2:0]  mode_q,  mode_d;
	logic [63:0] store_q, store_d;
	logic [3:0]  count_q, count_d;
	logic        flag_q,  flag_d;
	logic [15:0] line_q,  line_d;
	logic [11:0] col_q,   col_d;
	logic [15:0] tline_q, tline_d;
	logic [11:0] tcol_q,  tcol_d;

	logic [7:0]  b;
	logic        is_letter, is_digit, redo;
	logic        emit1, emit2;
	logic [5:0]  kind1, kind2;
	logic [63:0] app_store;
	logic [3:0]  app_count;
	logic        app_flag;
	ats_out_t    tok1, tok2;

	assign b         = word.data_byte;
	assign is_letter = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	assign is_digit  = (b >= 8'h30 && b <= 8'h39);

	// Append the byte, or mark the lexeme as too long once the store is full.
	always_comb begin
		app_store = store_q;
		app_count = count_q;
		app_flag  = flag_q;
		if (count_q < MAX_LEN) begin
			app_store = store_q | ({56'd0, b} << {count_q[2:0], 3'b000});
			app_count = count_q + 4'd1;
		end else begin
			app_flag = 1'b1;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		store_d = store_q;
		count_d = count_q;
		flag_d  = flag_q;
		tline_d = tline_q;
		tcol_d  = tcol_q;
		emit1   = 1'b0;
		kind1   = KIND_LABEL;
		redo    = 1'b0;

		unique case (mode_q)
			MODE_WORD: begin
				if (is_letter) begin
					store_d = app_store;
					count_d = app_count;
					flag_d  = app_flag;
				end else begin
					emit1  = 1'b1;
					kind1  = word_kind(store_q, flag_q, b == CHR_COLON);
					mode_d = MODE_IDLE;
					redo   = (kind1 != KIND_LABEL_DEF);
				end
			end
			MODE_INT: begin
				if (is_digit || b == CHR_DOT) begin
					store_d = app_store;
					count_d = app_count;
					flag_d  = app_flag;
					if (b == CHR_DOT) begin
						mode_d = MODE_FLOAT;
					end
				end else begin
					emit1  = 1'b1;
					kind1  = flag_q ? KIND_TOO_LONG : KIND_INT;
					mode_d = MODE_IDLE;
					redo   = 1'b1;
				end
			end
			MODE_FLOAT: begin
				if (is_digit) begin
					store_d = app_store;
					count_d = app_count;
					flag_d  = app_flag;
				end else begin
					emit1  = 1'b1;
					kind1  = flag_q ? KIND_TOO_LONG : KIND_FLOAT;
					mode_d = MODE_IDLE;
					redo   = 1'b1;
				end
			end
			MODE_CHAR_OPEN: begin
				store_d = app_store;
				count_d = app_count;
				flag_d  = app_flag;
				mode_d  = MODE_CHAR_CLOSE;
			end
			MODE_CHAR_CLOSE: begin
				emit1  = 1'b1;
				mode_d = MODE_IDLE;
				if (b == CHR_QUOTE) begin
					kind1 = KIND_CHAR;
				end else begin
					kind1 = KIND_UNCLOSED;
					redo  = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (b == CHR_NEWLINE) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				redo   = 1'b1;
			end
		endcase

		// A byte that closed a token, or that arrives while idle, may open a new one.
		if (redo) begin
			priority if (is_letter || is_digit) begin
				store_d = {56'd0, b};
				count_d = 4'd1;
				flag_d  = 1'b0;
				tline_d = line_q;
				tcol_d  = col_q;
				mode_d  = is_letter ? MODE_WORD : MODE_INT;
			end else if (b == CHR_QUOTE) begin
				store_d = '0;
				count_d = 4'd0;
				flag_d  = 1'b0;
				tline_d = line_q;
				tcol_d  = col_q;
				mode_d  = MODE_CHAR_OPEN;
			end else if (b == CHR_SEMI) begin
				mode_d = MODE_COMMENT;
			end else begin
				mode_d = MODE_IDLE;
			end
		end

		if (b == CHR_NEWLINE) begin
			line_d = (line_q < LINE_MAX) ? line_q + 16'd1 : line_q;
			col_d  = 12'd1;
		end else begin
			line_d = line_q;
			col_d  = (col_q < COL_MAX) ? col_q + 12'd1 : col_q;
		end

		// End of text flushes whatever token is still open after this byte.
		emit2 = 1'b0;
		kind2 = KIND_UNCLOSED;
		if (word.end_of_text) begin
			unique case (mode_d)
				MODE_WORD: begin
					emit2 = 1'b1;
					kind2 = word_kind(store_d, flag_d, 1'b0);
				end
				MODE_INT: begin
					emit2 = 1'b1;
					kind2 = flag_d ? KIND_TOO_LONG : KIND_INT;
				end
				MODE_FLOAT: begin
					emit2 = 1'b1;
					kind2 = flag_d ? KIND_TOO_LONG : KIND_FLOAT;
				end
				MODE_CHAR_OPEN, MODE_CHAR_CLOSE: begin
					emit2 = 1'b1;
					kind2 = KIND_UNCLOSED;
				end
				default: begin
					emit2 = 1'b0;
				end
			endcase
		end

		tok1.token_kind    = kind1;
		tok1.start_line    = tline_q;
		tok1.start_column  = tcol_q;
		tok1.lexeme_length = flag_q ? MAX_LEN : count_q;
		tok1.lexeme_bytes  = store_q;
		tok1.last_of_run   = !emit2;

		tok2.token_kind    = kind2;
		tok2.start_line    = tline_d;
		tok2.start_column  = tcol_d;
		tok2.lexeme_length = flag_d ? MAX_LEN : count_d;
		tok2.lexeme_bytes  = store_d;
		tok2.last_of_run   = 1'b1;

		pair.count  = {1'b0, emit1} + {1'b0, emit2};
		pair.first  = emit1 ? tok1 : tok2;
		pair.second = tok2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			store_q <= '0;
			count_q <= 4'd0;
			flag_q  <= 1'b0;
			line_q  <= 16'd1;
			col_q   <= 12'd1;
			tline_q <= 16'd1;
			tcol_q  <= 12'd1;
		end else if (step) begin
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			if (word.end_of_text) begin
				mode_q  <= MODE_IDLE;
				store_q <= '0;
				count_q <= 4'd0;
				flag_q  <= 1'b0;
				line_q  <= 16'd1;
				col_q   <= 12'd1;
			end else begin
				mode_q  <= mode_d;
				store_q <= store_d;
				count_q <= count_d;
				flag_q  <= flag_d;
				line_q  <= line_d;
				col_q   <= col_d;
			end
		end
	end

endmodule

[design/ats_out.sv]
// Result register holding up to two tokens and handing them out one word at a time.
module ats_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ats_pkg::ats_pair_t pair,
	input  logic               out_ready,
	output logic               out_valid,
	output ats_pkg::ats_out_t  out_word,
	output logic               free
);
	import ats_pkg::*;

	ats_out_t   first_s2, second_s2;
	logic [1:0] count_s2;
	logic       sel_s2;
	logic       pop, last;

	assign out_valid = (count_s2 != 2'd0);
	assign out_word  = sel_s2 ? second_s2 : first_s2;
	assign pop       = out_valid && out_ready;
	assign last      = sel_s2 || (count_s2 == 2'd1);
	assign free      = !out_valid || (pop && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_s2 <= 2'd0;
			sel_s2   <= 1'b0;
		end else if (load) begin
			count_s2 <= pair.count;
			sel_s2   <= 1'b0;
		end else if (pop) begin
			if (last) begin
				count_s2 <= 2'd0;
				sel_s2   <= 1'b0;
			end else begin
				sel_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_s2  <= pair.first;
			second_s2 <= pair.second;
		end
	end

endmodule
